// ----- rtl/tsew_pkg.sv -----
`timescale 1ns / 1ps

package tsew_pkg;

  localparam int SHADE_BITS = 24;

  // Request codes carried on req_type.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Walker indexes.
  typedef logic [1:0] walker_t;
  localparam walker_t WALK_UPPER = 2'd0;  // top to middle
  localparam walker_t WALK_LOWER = 2'd1;  // middle to bottom
  localparam walker_t WALK_LONG  = 2'd2;  // top to bottom

  typedef struct packed {
    logic    capture;  // latch vertices and shade of a load transaction
    logic    sort;     // register the vertices sorted by row
    logic    setup;    // initialize the three walkers
    logic    step;     // one error-update iteration of walker sel
    walker_t sel;
    logic    emit;     // load the result register
    logic    span;     // result carries a span
    logic    done;     // triangle fully walked
  } dp_cmd_t;

  typedef struct packed {
    logic step_fin;         // selected walker moves to the next row this iteration
    logic long_at_bottom;
    logic upper_at_mid;
    logic lower_at_bottom;
  } dp_status_t;

endpackage

// ----- rtl/tsew_datapath.sv -----
`timescale 1ns / 1ps

module tsew_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tsew_pkg::dp_cmd_t                    cmd,
  output tsew_pkg::dp_status_t                 status,
  input  logic signed [COORD_BITS-1:0]         ax,
  input  logic signed [COORD_BITS-1:0]         ay,
  input  logic signed [COORD_BITS-1:0]         bx,
  input  logic signed [COORD_BITS-1:0]         by_row,
  input  logic signed [COORD_BITS-1:0]         cx,
  input  logic signed [COORD_BITS-1:0]         cy,
  input  logic [tsew_pkg::SHADE_BITS-1:0]      shade_in,
  output logic                                 span_valid,
  output logic signed [COORD_BITS-1:0]         span_row,
  output logic signed [COORD_BITS-1:0]         x_from,
  output logic signed [COORD_BITS-1:0]         x_to,
  output logic [tsew_pkg::SHADE_BITS-1:0]      shade_out,
  output logic                                 tri_done
);
  import tsew_pkg::*;

  localparam int EW = COORD_BITS + 2;

  // Captured vertices of a load transaction.
  logic signed [COORD_BITS-1:0] raw_x [3];
  logic signed [COORD_BITS-1:0] raw_y [3];
  logic [SHADE_BITS-1:0]        held_shade;

  // Sorted vertices: 0 top, 1 middle, 2 bottom.
  logic signed [COORD_BITS-1:0] srt_x [3];
  logic signed [COORD_BITS-1:0] srt_y [3];
  logic signed [COORD_BITS-1:0] net_x [3];
  logic signed [COORD_BITS-1:0] net_y [3];

  // Walker state.
  logic signed [COORD_BITS-1:0] edge_col [3];
  logic signed [COORD_BITS-1:0] edge_row [3];
  logic [COORD_BITS-1:0]        edge_dx [3];
  logic [COORD_BITS-1:0]        edge_dy [3];
  logic                         edge_left [3];
  logic signed [EW-1:0]         edge_err [3];
  logic signed [COORD_BITS-1:0] mid_row;
  logic signed [COORD_BITS-1:0] bottom_row;

  // Setup values.
  logic signed [COORD_BITS-1:0] su_x0 [3];
  logic signed [COORD_BITS-1:0] su_y0 [3];
  logic signed [COORD_BITS-1:0] su_x1 [3];
  logic signed [COORD_BITS-1:0] su_y1 [3];
  logic [COORD_BITS-1:0]        su_dx [3];
  logic [COORD_BITS-1:0]        su_dy [3];
  logic                         su_left [3];
  logic signed [EW-1:0]         su_err [3];

  // Shared step unit.
  logic signed [EW-1:0]         st_err;
  logic signed [EW-1:0]         st_dx;
  logic signed [EW-1:0]         st_dy;
  logic                         st_move;
  logic                         st_fin;
  logic signed [EW-1:0]         st_err_next;
  logic signed [COORD_BITS-1:0] st_col_next;
  logic signed [COORD_BITS-1:0] st_row_next;

  // Three compare-and-swaps; a swap happens only on a strictly greater upper row.
  always_comb begin
    net_x = raw_x;
    net_y = raw_y;
    if (net_y[0] > net_y[1]) begin
      net_x[0] = raw_x[1];
      net_y[0] = raw_y[1];
      net_x[1] = raw_x[0];
      net_y[1] = raw_y[0];
    end
    if (net_y[1] > net_y[2]) begin
      {net_x[1], net_x[2]} = {net_x[2], net_x[1]};
      {net_y[1], net_y[2]} = {net_y[2], net_y[1]};
    end
    if (net_y[0] > net_y[1]) begin
      {net_x[0], net_x[1]} = {net_x[1], net_x[0]};
      {net_y[0], net_y[1]} = {net_y[1], net_y[0]};
    end
  end

  always_comb begin
    su_x0[WALK_UPPER] = srt_x[0];
    su_y0[WALK_UPPER] = srt_y[0];
    su_x1[WALK_UPPER] = srt_x[1];
    su_y1[WALK_UPPER] = srt_y[1];
    su_x0[WALK_LOWER] = srt_x[1];
    su_y0[WALK_LOWER] = srt_y[1];
    su_x1[WALK_LOWER] = srt_x[2];
    su_y1[WALK_LOWER] = srt_y[2];
    su_x0[WALK_LONG]  = srt_x[0];
    su_y0[WALK_LONG]  = srt_y[0];
    su_x1[WALK_LONG]  = srt_x[2];
    su_y1[WALK_LONG]  = srt_y[2];
  end

  for (genvar k = 0; k < 3; k++) begin : g_setup
    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic signed [COORD_BITS:0] abs_x;
    logic signed [COORD_BITS:0] abs_y;

    always_comb begin
      diff_x = {su_x1[k][COORD_BITS-1], su_x1[k]} - {su_x0[k][COORD_BITS-1], su_x0[k]};
      diff_y = {su_y1[k][COORD_BITS-1], su_y1[k]} - {su_y0[k][COORD_BITS-1], su_y0[k]};
      abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
      abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
      su_dx[k]   = abs_x[COORD_BITS-1:0];
      su_dy[k]   = abs_y[COORD_BITS-1:0];
      su_left[k] = !(su_x0[k] < su_x1[k]);
      // Halving truncates toward zero, so the negative branch halves dy first.
      if (su_dx[k] > su_dy[k]) begin
        su_err[k] = {3'b000, su_dx[k][COORD_BITS-1:1]};
      end else begin
        su_err[k] = -{3'b000, su_dy[k][COORD_BITS-1:1]};
      end
    end
  end

  always_comb begin
    st_err  = edge_err[cmd.sel];
    st_dx   = {2'b00, edge_dx[cmd.sel]};
    st_dy   = {2'b00, edge_dy[cmd.sel]};
    st_move = st_err > -st_dx;
    st_fin  = st_err < st_dy;
    st_err_next = st_err - (st_move ? st_dy : '0) + (st_fin ? st_dx : '0);
    st_col_next = edge_col[cmd.sel];
    if (st_move) begin
      st_col_next = edge_left[cmd.sel] ? edge_col[cmd.sel] - COORD_BITS'(1)
                                       : edge_col[cmd.sel] + COORD_BITS'(1);
    end
    st_row_next = st_fin ? edge_row[cmd.sel] + COORD_BITS'(1) : edge_row[cmd.sel];
  end

  assign status.step_fin        = st_fin;
  assign status.long_at_bottom  = edge_row[WALK_LONG] == bottom_row;
  assign status.upper_at_mid    = edge_row[WALK_UPPER] == mid_row;
  assign status.lower_at_bottom = edge_row[WALK_LOWER] == bottom_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_shade <= '0;
    end else if (cmd.capture) begin
      held_shade <= shade_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_x[0] <= ax;
      raw_y[0] <= ay;
      raw_x[1] <= bx;
      raw_y[1] <= by_row;
      raw_x[2] <= cx;
      raw_y[2] <= cy;
    end
    if (cmd.sort) begin
      srt_x <= net_x;
      srt_y <= net_y;
    end
    if (cmd.setup) begin
      edge_col   <= su_x0;
      edge_row   <= su_y0;
      edge_dx    <= su_dx;
      edge_dy    <= su_dy;
      edge_left  <= su_left;
      edge_err   <= su_err;
      mid_row    <= srt_y[1];
      bottom_row <= srt_y[2];
    end else if (cmd.step) begin
      edge_err[cmd.sel] <= st_err_next;
      edge_col[cmd.sel] <= st_col_next;
      edge_row[cmd.sel] <= st_row_next;
    end
    if (cmd.emit) begin
      span_valid <= cmd.span;
      span_row   <= cmd.span ? edge_row[cmd.sel] : '0;
      x_from     <= cmd.span ? edge_col[cmd.sel] : '0;
      x_to       <= cmd.span ? edge_col[WALK_LONG] : '0;
      shade_out  <= held_shade;
      tri_done   <= cmd.done;
    end
  end

endmodule

// ----- rtl/tsew_ctrl.sv -----
`timescale 1ns / 1ps

module tsew_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsew_pkg::dp_cmd_t    cmd,
  input  tsew_pkg::dp_status_t status
);
  import tsew_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_SETUP,
    S_CHECK,
    S_STEP_LONG,
    S_PICK,
    S_STEP_SHORT,
    S_RESULT
  } state_t;

  state_t  state;
  logic    all_finished;
  logic    upper_finished;
  logic    span;
  walker_t sel;
  logic    accept;
  logic    emit;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign emit     = (state == S_RESULT) && (!out_valid || out_ready);

  always_comb begin
    cmd.capture = accept && (req_type == REQ_LOAD);
    cmd.sort    = state == S_SORT;
    cmd.setup   = state == S_SETUP;
    cmd.step    = (state == S_STEP_LONG) || (state == S_STEP_SHORT);
    cmd.sel     = (state == S_STEP_LONG) ? WALK_LONG : sel;
    cmd.emit    = emit;
    cmd.span    = span;
    cmd.done    = all_finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      all_finished   <= 1'b1;
      upper_finished <= 1'b0;
      span           <= 1'b0;
      sel            <= WALK_UPPER;
      out_valid      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            span <= 1'b0;
            if (req_type == REQ_LOAD) begin
              all_finished   <= 1'b0;
              upper_finished <= 1'b0;
              state          <= S_SORT;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SORT: begin
          state <= S_SETUP;
        end
        S_SETUP: begin
          state <= S_RESULT;
        end
        S_CHECK: begin
          if (all_finished) begin
            state <= S_RESULT;
          end else if (status.long_at_bottom) begin
            all_finished <= 1'b1;
            state        <= S_RESULT;
          end else begin
            state <= S_STEP_LONG;
          end
        end
        S_STEP_LONG: begin
          if (status.step_fin) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (!upper_finished && !status.upper_at_mid) begin
            sel   <= WALK_UPPER;
            state <= S_STEP_SHORT;
          end else begin
            upper_finished <= 1'b1;
            if (status.lower_at_bottom) begin
              all_finished <= 1'b1;
              state        <= S_RESULT;
            end else begin
              sel   <= WALK_LOWER;
              state <= S_STEP_SHORT;
            end
          end
        end
        S_STEP_SHORT: begin
          if (status.step_fin) begin
            span  <= 1'b1;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/triangle_scanline_edge_walker.sv -----
`timescale 1ns / 1ps
// Flat-shaded triangle scanline walker.
// Input channel (in_valid/in_ready): req_type selects a load transaction, which
// takes three vertices and a shade, or an advance transaction, which walks one
// scanline. Output channel (out_valid/out_ready): one result per input
// transaction, holding an optional span (row, short-edge column, long-edge
// column), the held shade and the done flag.
// A load returns its result straight after sort and setup; an advance on a
// finished triangle, or one that finds the long edge at the bottom row, goes
// straight from its check to the result; any other advance steps the long edge
// and then the upper or lower edge (only the long edge when the lower edge
// already sits at the bottom row) by Bresenham error updates until each
// reaches the next row (one update, plus one per extra column step on shallow
// edges). All edges share a single step unit, one update per cycle. One
// transaction is in flight at a time; the next is accepted the cycle after the
// result is loaded into the output register, and input keeps moving while
// that result waits for the receiver.
// A stalled receiver holds the result stable and, once the next item is done,
// blocks new input. Reset empties the output register and marks the walk
// finished, so an advance before any load returns no span with done set.
module triangle_scanline_edge_walker #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic signed [COORD_BITS-1:0]    ax,
  input  logic signed [COORD_BITS-1:0]    ay,
  input  logic signed [COORD_BITS-1:0]    bx,
  input  logic signed [COORD_BITS-1:0]    by_row,
  input  logic signed [COORD_BITS-1:0]    cx,
  input  logic signed [COORD_BITS-1:0]    cy,
  input  logic [tsew_pkg::SHADE_BITS-1:0] shade_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            span_valid,
  output logic signed [COORD_BITS-1:0]    span_row,
  output logic signed [COORD_BITS-1:0]    x_from,
  output logic signed [COORD_BITS-1:0]    x_to,
  output logic [tsew_pkg::SHADE_BITS-1:0] shade_out,
  output logic                            tri_done
);
  import tsew_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tsew_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  tsew_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .ax         (ax),
    .ay         (ay),
    .bx         (bx),
    .by_row     (by_row),
    .cx         (cx),
    .cy         (cy),
    .shade_in   (shade_in),
    .span_valid (span_valid),
    .span_row   (span_row),
    .x_from     (x_from),
    .x_to       (x_to),
    .shade_out  (shade_out),
    .tri_done   (tri_done)
  );

endmodule

// ----- rtl/tsew_checker.sv -----
`timescale 1ns / 1ps

module tsew_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            span_valid,
  input logic signed [COORD_BITS-1:0]    span_row,
  input logic signed [COORD_BITS-1:0]    x_from,
  input logic signed [COORD_BITS-1:0]    x_to,
  input logic [tsew_pkg::SHADE_BITS-1:0] shade_out,
  input logic                            tri_done
);

  // A result waiting on the receiver must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(span_valid) && $stable(span_row)
      && $stable(x_from) && $stable(x_to) && $stable(shade_out) && $stable(tri_done))
    else $error("result changed while stalled");

  // A span is only given while the walk is still in progress.
  a_span_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && span_valid |-> !tri_done)
    else $error("span reported on a finished triangle");

  // A result without a span carries zero coordinates.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !span_valid |-> span_row == '0 && x_from == '0 && x_to == '0)
    else $error("coordinates on a result without a span");

  // One transaction at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

endmodule

bind triangle_scanline_edge_walker tsew_checker #(
  .COORD_BITS (COORD_BITS)
) u_tsew_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .span_valid (span_valid),
  .span_row   (span_row),
  .x_from     (x_from),
  .x_to       (x_to),
  .shade_out  (shade_out),
  .tri_done   (tri_done)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tsew_pkg::*;

  localparam int CB = 12;
  localparam int IDLE_LIMIT = 60000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct {
    logic                  kind;
    logic signed [CB-1:0]  ax;
    logic signed [CB-1:0]  ay;
    logic signed [CB-1:0]  bx;
    logic signed [CB-1:0]  by_r;
    logic signed [CB-1:0]  cx;
    logic signed [CB-1:0]  cy;
    logic [SHADE_BITS-1:0] shade;
  } tri_req_t;

  typedef struct packed {
    logic                  has_span;
    logic [CB-1:0]         row;
    logic [CB-1:0]         xf;
    logic [CB-1:0]         xt;
    logic [SHADE_BITS-1:0] shade;
    logic                  done;
  } span_res_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         req_type = REQ_LOAD;
  logic signed [CB-1:0]         ax = '0;
  logic signed [CB-1:0]         ay = '0;
  logic signed [CB-1:0]         bx = '0;
  logic signed [CB-1:0]         by_row = '0;
  logic signed [CB-1:0]         cx = '0;
  logic signed [CB-1:0]         cy = '0;
  logic [SHADE_BITS-1:0]        shade_in = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         span_valid;
  logic signed [CB-1:0]         span_row;
  logic signed [CB-1:0]         x_from;
  logic signed [CB-1:0]         x_to;
  logic [SHADE_BITS-1:0]        shade_out;
  logic                         tri_done;

  tri_req_t  triangle_reqs[$];
  span_res_t pending_spans[$];
  tri_req_t  cur_req;
  span_res_t want;

  // Walker state of the scanline predictor.
  int   w_col[3];
  int   w_row[3];
  int   w_dx[3];
  int   w_dy[3];
  bit   w_left[3];
  int   w_err[3];
  int   mid_r;
  int   bot_r;
  bit   upper_fin;
  bit   all_fin;
  logic [SHADE_BITS-1:0] held_shade;

  int  errors = 0;
  int  n_items = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  always #5 clk = ~clk;

  triangle_scanline_edge_walker #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .ax(ax), .ay(ay), .bx(bx), .by_row(by_row), .cx(cx), .cy(cy),
    .shade_in(shade_in),
    .out_valid(out_valid), .out_ready(out_ready), .span_valid(span_valid),
    .span_row(span_row), .x_from(x_from), .x_to(x_to),
    .shade_out(shade_out), .tri_done(tri_done)
  );

  function automatic void clear_walkers();
    for (int k = 0; k < 3; k++) begin
      w_col[k] = 0;
      w_row[k] = 0;
      w_dx[k] = 0;
      w_dy[k] = 0;
      w_left[k] = 1'b0;
      w_err[k] = 0;
    end
    mid_r = 0;
    bot_r = 0;
    upper_fin = 1'b0;
    all_fin = 1'b1;
    held_shade = '0;
  endfunction

  function automatic void setup_walker(walker_t k, int x0, int y0, int x1, int y1);
    int dx;
    int dy;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    w_dx[k] = dx;
    w_dy[k] = dy;
    w_left[k] = !(x0 < x1);
    w_err[k] = (dx > dy ? dx : -dy) / 2;
    w_col[k] = x0;
    w_row[k] = y0;
  endfunction

  // Runs Bresenham iterations until the walker drops to the next row.
  function automatic void step_walker(walker_t k);
    int lim;
    int e;
    lim = 1 << (CB + 2);
    for (int n = 0; n < lim; n++) begin
      e = w_err[k];
      if (e > -w_dx[k]) begin
        w_err[k] -= w_dy[k];
        w_col[k] += w_left[k] ? -1 : 1;
      end
      if (e < w_dy[k]) begin
        w_err[k] += w_dx[k];
        w_row[k] += 1;
        return;
      end
    end
  endfunction

  function automatic span_res_t predict_span(tri_req_t r);
    int vx[3];
    int vy[3];
    int f;
    int s;
    int t;
    int tmp;
    bit ok;
    int row_i;
    int xf_i;
    int xt_i;
    span_res_t res;
    ok = 1'b0;
    row_i = 0;
    xf_i = 0;
    xt_i = 0;
    if (r.kind == REQ_LOAD) begin
      vx[0] = int'(r.ax); vy[0] = int'(r.ay);
      vx[1] = int'(r.bx); vy[1] = int'(r.by_r);
      vx[2] = int'(r.cx); vy[2] = int'(r.cy);
      f = 0; s = 1; t = 2;
      if (vy[f] > vy[s]) begin tmp = s; s = f; f = tmp; end
      if (vy[s] > vy[t]) begin tmp = t; t = s; s = tmp; end
      if (vy[f] > vy[s]) begin tmp = s; s = f; f = tmp; end
      setup_walker(WALK_UPPER, vx[f], vy[f], vx[s], vy[s]);
      setup_walker(WALK_LOWER, vx[s], vy[s], vx[t], vy[t]);
      setup_walker(WALK_LONG, vx[f], vy[f], vx[t], vy[t]);
      mid_r = vy[s];
      bot_r = vy[t];
      upper_fin = 1'b0;
      all_fin = 1'b0;
      held_shade = r.shade;
    end else if (!all_fin) begin
      if (w_row[WALK_LONG] == bot_r) begin
        all_fin = 1'b1;
      end else begin
        step_walker(WALK_LONG);
        if (!upper_fin && w_row[WALK_UPPER] != mid_r) begin
          step_walker(WALK_UPPER);
          ok = 1'b1;
          row_i = w_row[WALK_UPPER];
          xf_i = w_col[WALK_UPPER];
          xt_i = w_col[WALK_LONG];
        end else begin
          upper_fin = 1'b1;
          if (w_row[WALK_LOWER] == bot_r) begin
            all_fin = 1'b1;
          end else begin
            step_walker(WALK_LOWER);
            ok = 1'b1;
            row_i = w_row[WALK_LOWER];
            xf_i = w_col[WALK_LOWER];
            xt_i = w_col[WALK_LONG];
          end
        end
      end
    end
    res.has_span = ok;
    res.row = row_i[CB-1:0];
    res.xf = xf_i[CB-1:0];
    res.xt = xt_i[CB-1:0];
    res.shade = held_shade;
    res.done = all_fin;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_load(int x0, int y0, int x1, int y1, int x2, int y2, int shd);
    tri_req_t r;
    r.kind = REQ_LOAD;
    r.ax = x0[CB-1:0];
    r.ay = y0[CB-1:0];
    r.bx = x1[CB-1:0];
    r.by_r = y1[CB-1:0];
    r.cx = x2[CB-1:0];
    r.cy = y2[CB-1:0];
    r.shade = shd[SHADE_BITS-1:0];
    triangle_reqs.push_back(r);
    n_items++;
  endtask

  // Coordinates of an advance transaction are ignored, so they carry noise.
  task automatic add_advance(int count);
    tri_req_t r;
    repeat (count) begin
      r.kind = REQ_ADVANCE;
      r.ax = CB'($urandom);
      r.ay = CB'($urandom);
      r.bx = CB'($urandom);
      r.by_r = CB'($urandom);
      r.cx = CB'($urandom);
      r.cy = CB'($urandom);
      r.shade = SHADE_BITS'($urandom);
      triangle_reqs.push_back(r);
      n_items++;
    end
  endtask

  // Mostly small triangles anywhere on the screen; a few have columns that
  // spread over the full range, which makes for very shallow edges.
  task automatic add_random_triangle(output int span);
    int rows[3];
    int cols[3];
    int base_r;
    int base_c;
    int lo;
    int hi;
    base_r = $urandom_range(0, 4095 - 12) - 2048;
    for (int k = 0; k < 3; k++) rows[k] = base_r + $urandom_range(0, 12);
    case ($urandom_range(0, 19))
      0: begin rows[1] = rows[0]; rows[2] = rows[0]; end
      1, 2: rows[1] = rows[0];
      3, 4: rows[2] = rows[1];
      5: rows[2] = rows[0];
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      for (int k = 0; k < 3; k++) cols[k] = $urandom_range(0, 4095) - 2048;
    end else begin
      base_c = $urandom_range(0, 4095 - 80) - 2048;
      for (int k = 0; k < 3; k++) cols[k] = base_c + $urandom_range(0, 80);
    end
    add_load(cols[0], rows[0], cols[1], rows[1], cols[2], rows[2], $urandom);
    lo = rows[0];
    hi = rows[0];
    for (int k = 1; k < 3; k++) begin
      if (rows[k] < lo) lo = rows[k];
      if (rows[k] > hi) hi = rows[k];
    end
    span = hi - lo;
  endtask

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  // Driver: a new transaction is presented only once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_spans.push_back(predict_span(cur_req));
        send_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (triangle_reqs.size() > 0) begin
          cur_req = triangle_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_req.kind;
          ax <= cur_req.ax;
          ay <= cur_req.ay;
          bx <= cur_req.bx;
          by_row <= cur_req.by_r;
          cx <= cur_req.cx;
          cy <= cur_req.cy;
          shade_in <= cur_req.shade;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and throttles the receiver.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_spans.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual span %b row %h from %h to %h shade %h done %b",
                   $time, span_valid, span_row, x_from, x_to, shade_out, tri_done);
        end else begin
          want = pending_spans.pop_front();
          cmp_field("span_valid", 32'(want.has_span), 32'(span_valid));
          cmp_field("span_row", 32'(want.row), 32'(unsigned'(span_row)));
          cmp_field("x_from", 32'(want.xf), 32'(unsigned'(x_from)));
          cmp_field("x_to", 32'(want.xt), 32'(unsigned'(x_to)));
          cmp_field("shade_out", 32'(want.shade), 32'(shade_out));
          cmp_field("tri_done", 32'(want.done), 32'(tri_done));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int span;
    int r;
    int nadv;
    clear_walkers();

    // Advance before any load finds the walk already finished.
    add_advance(1);
    // All three rows equal, with column extremes: done at once, then stays done.
    add_load(-2048, -2048, 2047, -2048, 0, -2048, 0);
    add_advance(2);
    // Flat top at the bottom of the row range, very shallow edges.
    add_load(2047, 2045, -2048, 2045, 0, 2047, 24'hFFFFFF);
    add_advance(3);
    // Flat bottom.
    add_load(5, -3, -4, 1, 9, 1, 24'h123456);
    add_advance(5);
    // Vertices given bottom first, so every compare-and-swap fires.
    add_load(0, 6, -6, 3, 3, 0, 24'hA5C30F);
    add_advance(7);
    // Widest possible upper edge; the walk is cut short by the next load.
    add_load(-2048, -2048, 2047, -2047, -2048, -2046, 24'h5A3CF0);
    add_advance(1);

    while (n_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      add_random_triangle(span);
      if (r < 75) nadv = span + 1 + $urandom_range(0, 2);
      else if (r < 90) nadv = $urandom_range(0, span);
      else nadv = $urandom_range(0, 3);
      add_advance(nadv);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (triangle_reqs.size() > 0 || in_valid || pending_spans.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
